// ===== src/wdt_pkg.sv =====
// Shared widths, codes and types of the watchdog timer register block.
`default_nettype none

package wdt_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned SEL_W  = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned CTRL_W = 2;
  localparam int unsigned QW     = DATA_W;

  localparam int unsigned CTRL_EN_BIT = 0;

  localparam int unsigned     TICK_NS_DEF = 1000000;
  localparam logic [DATA_W-1:0] UNLOCK_KEY = 32'd1515870810;
  localparam logic [DATA_W-1:0] COUNT_MAX  = '1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [SEL_W-1:0] {
    REG_CTRL    = 3'd0,
    REG_LOAD    = 3'd1,
    REG_CURRENT = 3'd2,
    REG_STATUS  = 3'd3,
    REG_INT_EN  = 3'd4,
    REG_LOCK    = 3'd5,
    REG_UNLOCK  = 3'd6
  } sel_t;

  // Work left for the counter stage once the front stage has seen a word.
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_TICK      = 3'd1,
    CMD_LOAD      = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_RD_COUNT  = 3'd4,
    CMD_RD_STATUS = 3'd5,
    CMD_RD_DATA   = 3'd6
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              sat;
    logic [DATA_W-1:0] data;
  } wdt_cmd_t;

endpackage

`default_nettype wire

// ===== src/wdt_in_if.sv =====
// Input channel of the watchdog timer register block.
`default_nettype none

interface wdt_in_if;
  import wdt_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SEL_W-1:0]  reg_select;
  logic [DATA_W-1:0] write_value;
  logic [TIME_W-1:0] now_ns;

  modport source (output valid, output operation, output reg_select,
                  output write_value, output now_ns, input ready);
  modport sink   (input valid, input operation, input reg_select,
                  input write_value, input now_ns, output ready);
endinterface

`default_nettype wire

// ===== src/wdt_out_if.sv =====
// Result channel of the watchdog timer register block.
`default_nettype none

interface wdt_out_if;
  import wdt_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              timeout_flag;

  modport source (output valid, output read_data, output timeout_flag, input ready);
  modport sink   (input valid, input read_data, input timeout_flag, output ready);
endinterface

`default_nettype wire

// ===== src/wdt_front.sv =====
// Input register, register file and timestamp tracking of the watchdog block.
`default_nettype none

module wdt_front #(
  parameter int unsigned TICK_NS = wdt_pkg::TICK_NS_DEF,
  localparam int unsigned RW = $clog2(TICK_NS + 1) + wdt_pkg::QW
) (
  input  logic              clk,
  input  logic              rst_n,
  wdt_in_if.sink            in_ch,
  output logic              dn_valid,
  input  logic              dn_ready,
  output wdt_pkg::wdt_cmd_t dn_cmd,
  output logic [RW-1:0]     dn_rem
);
  import wdt_pkg::*;

  localparam logic [TIME_W-1:0] TICK_LEN = TIME_W'(TICK_NS);
  localparam logic [TIME_W-1:0] SAT_LEN  = TICK_LEN << QW;

  logic              v_r;
  logic [OP_W-1:0]   op_r;
  logic [SEL_W-1:0]  sel_r;
  logic [DATA_W-1:0] wv_r;
  logic [TIME_W-1:0] now_r;

  logic [CTRL_W-1:0] ctrl_r, ctrl_nxt;
  logic [DATA_W-1:0] reload_r, reload_nxt;
  logic              irq_r, irq_nxt;
  logic              lock_r, lock_nxt;
  logic [TIME_W-1:0] stamp_r, stamp_nxt;

  logic [TIME_W-1:0] elapsed;
  logic              move;

  assign in_ch.ready = !v_r || dn_ready;
  assign move        = v_r && dn_ready;
  assign dn_valid    = v_r;
  assign elapsed     = now_r - stamp_r;
  assign dn_rem      = elapsed[RW-1:0];

  always_comb begin
    ctrl_nxt   = ctrl_r;
    reload_nxt = reload_r;
    irq_nxt    = irq_r;
    lock_nxt   = lock_r;
    stamp_nxt  = stamp_r;
    dn_cmd     = '{cmd: CMD_NONE, sat: (elapsed >= SAT_LEN), data: '0};
    unique case (op_t'(op_r))
      OP_TICK: begin
        if (ctrl_r[CTRL_EN_BIT]) begin
          if (stamp_r == '0) begin
            stamp_nxt = now_r;
          end else if (elapsed >= TICK_LEN) begin
            stamp_nxt  = now_r;
            dn_cmd.cmd = CMD_TICK;
          end
        end
      end
      OP_READ: begin
        unique case (sel_t'(sel_r))
          REG_CTRL: begin
            dn_cmd.cmd  = CMD_RD_DATA;
            dn_cmd.data = {{(DATA_W-CTRL_W){1'b0}}, ctrl_r};
          end
          REG_LOAD: begin
            dn_cmd.cmd  = CMD_RD_DATA;
            dn_cmd.data = reload_r;
          end
          REG_CURRENT: dn_cmd.cmd = CMD_RD_COUNT;
          REG_STATUS:  dn_cmd.cmd = CMD_RD_STATUS;
          REG_INT_EN: begin
            dn_cmd.cmd  = CMD_RD_DATA;
            dn_cmd.data = {{(DATA_W-1){1'b0}}, irq_r};
          end
          REG_LOCK: begin
            dn_cmd.cmd  = CMD_RD_DATA;
            dn_cmd.data = {{(DATA_W-1){1'b0}}, lock_r};
          end
          default: ;
        endcase
      end
      OP_WRITE: begin
        unique case (sel_t'(sel_r))
          REG_CTRL: begin
            ctrl_nxt = wv_r[CTRL_W-1:0];
            if (wv_r[CTRL_EN_BIT]) begin
              dn_cmd.cmd  = CMD_LOAD;
              dn_cmd.data = reload_r;
            end
          end
          REG_LOAD: reload_nxt = wv_r;
          REG_STATUS: begin
            if (wv_r[0]) begin
              dn_cmd.cmd = CMD_CLEAR;
            end
          end
          REG_INT_EN: irq_nxt  = wv_r[0];
          REG_LOCK:   lock_nxt = 1'b1;
          REG_UNLOCK: begin
            if (wv_r == UNLOCK_KEY) begin
              lock_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= 1'b0;
      ctrl_r   <= '0;
      reload_r <= COUNT_MAX;
      irq_r    <= 1'b0;
      lock_r   <= 1'b1;
      stamp_r  <= '0;
    end else begin
      if (in_ch.ready) begin
        v_r <= in_ch.valid;
      end
      if (move) begin
        ctrl_r   <= ctrl_nxt;
        reload_r <= reload_nxt;
        irq_r    <= irq_nxt;
        lock_r   <= lock_nxt;
        stamp_r  <= stamp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      op_r  <= in_ch.operation;
      sel_r <= in_ch.reg_select;
      wv_r  <= in_ch.write_value;
      now_r <= in_ch.now_ns;
    end
  end

endmodule

`default_nettype wire

// ===== src/wdt_div.sv =====
// Two-stage reciprocal multiplier that turns elapsed nanoseconds into whole ticks.
`default_nettype none

module wdt_div #(
  parameter int unsigned TICK_NS = wdt_pkg::TICK_NS_DEF,
  localparam int unsigned RW = $clog2(TICK_NS + 1) + wdt_pkg::QW
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  wdt_pkg::wdt_cmd_t      up_cmd,
  input  logic [RW-1:0]          up_rem,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output wdt_pkg::wdt_cmd_t      dn_cmd,
  output logic [wdt_pkg::QW-1:0] dn_quo
);
  import wdt_pkg::*;

  localparam int unsigned PW    = 2 * TIME_W;
  localparam int unsigned HW    = TIME_W / 2;
  localparam int unsigned SHIFT = RW + $clog2(TICK_NS);

  // The quotient is the top part of the product with a rounded-up reciprocal.
  // With 2**l >= TICK_NS and the elapsed time below 2**RW, the rounding
  // error stays below one tick, so the quotient is exact.
  function automatic logic [TIME_W-1:0] recip_of(int unsigned divisor, int unsigned sh);
    logic [PW-1:0] scaled;
    scaled = PW'(1) << sh;
    return TIME_W'(scaled / PW'(divisor) + PW'(1));
  endfunction

  localparam logic [TIME_W-1:0] RECIP = recip_of(TICK_NS, SHIFT);
  localparam logic [HW-1:0]     M_LO  = RECIP[HW-1:0];
  localparam logic [HW-1:0]     M_HI  = RECIP[TIME_W-1:HW];

  logic              v0_r, v1_r;
  wdt_cmd_t          cmd0_r, cmd1_r;
  logic [TIME_W-1:0] ll_r, lh_r, hl_r, hh_r;
  logic [QW-1:0]     quo_r;
  logic [TIME_W-1:0] num;
  logic [PW-1:0]     prod;
  logic              rdy0, rdy1;

  assign num      = TIME_W'(up_rem);
  assign rdy1     = !v1_r || dn_ready;
  assign rdy0     = !v0_r || rdy1;
  assign up_ready = rdy0;
  assign dn_valid = v1_r;
  assign dn_cmd   = cmd1_r;
  assign dn_quo   = quo_r;

  assign prod = {{TIME_W{1'b0}}, ll_r}
              + {{HW{1'b0}}, lh_r, {HW{1'b0}}}
              + {{HW{1'b0}}, hl_r, {HW{1'b0}}}
              + {hh_r, {TIME_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_r <= up_valid;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      cmd0_r <= up_cmd;
      ll_r   <= {{HW{1'b0}}, num[HW-1:0]} * {{HW{1'b0}}, M_LO};
      lh_r   <= {{HW{1'b0}}, num[HW-1:0]} * {{HW{1'b0}}, M_HI};
      hl_r   <= {{HW{1'b0}}, num[TIME_W-1:HW]} * {{HW{1'b0}}, M_LO};
      hh_r   <= {{HW{1'b0}}, num[TIME_W-1:HW]} * {{HW{1'b0}}, M_HI};
    end
    if (rdy1) begin
      cmd1_r <= cmd0_r;
      quo_r  <= prod[SHIFT +: QW];
    end
  end

endmodule

`default_nettype wire

// ===== src/wdt_back.sv =====
// Down-counter, sticky timeout bit and result register of the watchdog block.
`default_nettype none

module wdt_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  wdt_pkg::wdt_cmd_t      up_cmd,
  input  logic [wdt_pkg::QW-1:0] up_quo,
  wdt_out_if.source              out_ch
);
  import wdt_pkg::*;

  logic              out_v_r;
  logic [DATA_W-1:0] rd_r, rd_nxt;
  logic [DATA_W-1:0] count_r, count_nxt;
  logic              to_r, to_nxt;
  logic [DATA_W-1:0] dec;
  logic              move;

  assign up_ready = !out_v_r || out_ch.ready;
  assign move     = up_valid && up_ready;
  assign dec      = up_cmd.sat ? COUNT_MAX : up_quo;

  assign out_ch.valid        = out_v_r;
  assign out_ch.read_data    = rd_r;
  assign out_ch.timeout_flag = to_r;

  always_comb begin
    count_nxt = count_r;
    to_nxt    = to_r;
    rd_nxt    = '0;
    unique case (up_cmd.cmd)
      CMD_NONE: ;
      CMD_TICK: begin
        if (dec >= count_r) begin
          count_nxt = '0;
          to_nxt    = 1'b1;
        end else begin
          count_nxt = count_r - dec;
        end
      end
      CMD_LOAD:      count_nxt = up_cmd.data;
      CMD_CLEAR:     to_nxt    = 1'b0;
      CMD_RD_COUNT:  rd_nxt    = count_r;
      CMD_RD_STATUS: rd_nxt    = {{(DATA_W-1){1'b0}}, to_r};
      CMD_RD_DATA:   rd_nxt    = up_cmd.data;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      count_r <= COUNT_MAX;
      to_r    <= 1'b0;
    end else begin
      if (up_ready) begin
        out_v_r <= up_valid;
      end
      if (move) begin
        count_r <= count_nxt;
        to_r    <= to_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      rd_r <= rd_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/watchdog_timer_registers.sv =====
// Watchdog timer register block: top level.
//
// Every word on in_ch is a time tick (operation 0, now_ns), a register read
// (operation 1) or a register write (operation 2, write_value). Every word
// gives exactly one word on out_ch: read_data for a read, zero otherwise,
// and the sticky timeout bit as it stands after that word.
// The front stage holds the control, load, interrupt enable and lock
// registers and the last timestamp; it also forms the elapsed time. A
// two-stage reciprocal multiplier then turns the elapsed time into whole
// ticks, with 32 by 32 bit partial products in its first stage and their
// sum in its second, and the last stage updates the down-counter and the
// timeout bit before the result register.
// When out_ch is not stalled, one word is accepted and one result is
// delivered in every cycle.
// Reset clears the pipeline and loads the register reset values; no
// clearing pass is needed, so in_ch may be used in the cycle after reset.
// When the receiver stalls, the result is held and the words behind it move
// up into empty stages; in_ch.ready falls only when every stage is full.
`default_nettype none

module watchdog_timer_registers #(
  parameter int unsigned TICK_NS = wdt_pkg::TICK_NS_DEF,
  localparam int unsigned RW = $clog2(TICK_NS + 1) + wdt_pkg::QW
) (
  input  logic      clk,
  input  logic      rst_n,
  wdt_in_if.sink    in_ch,
  wdt_out_if.source out_ch
);
  import wdt_pkg::*;

  logic          f2d_valid;
  logic          f2d_ready;
  wdt_cmd_t      f2d_cmd;
  logic [RW-1:0] f2d_rem;

  logic          d2b_valid;
  logic          d2b_ready;
  wdt_cmd_t      d2b_cmd;
  logic [QW-1:0] d2b_quo;

  wdt_front #(.TICK_NS(TICK_NS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (f2d_valid),
    .dn_ready (f2d_ready),
    .dn_cmd   (f2d_cmd),
    .dn_rem   (f2d_rem)
  );

  wdt_div #(.TICK_NS(TICK_NS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f2d_valid),
    .up_ready (f2d_ready),
    .up_cmd   (f2d_cmd),
    .up_rem   (f2d_rem),
    .dn_valid (d2b_valid),
    .dn_ready (d2b_ready),
    .dn_cmd   (d2b_cmd),
    .dn_quo   (d2b_quo)
  );

  wdt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (d2b_valid),
    .up_ready (d2b_ready),
    .up_cmd   (d2b_cmd),
    .up_quo   (d2b_quo),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ===== src/wdt_chk.sv =====
// Port-level checker of the watchdog timer register block and its binding.
`default_nettype none

module wdt_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [wdt_pkg::DATA_W-1:0] out_read_data,
  input logic                       out_timeout_flag
);
  import wdt_pkg::*;

  // The output channel is idle right after a reset cycle.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input side can only be blocked by a result that is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input blocked without a stalled result");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_read_data) && $stable(out_timeout_flag)))
    else $error("result changed while stalled");

endmodule

bind watchdog_timer_registers wdt_chk u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_read_data    (out_ch.read_data),
  .out_timeout_flag (out_ch.timeout_flag)
);

`default_nettype wire
